@@ hw/rtl/biq_pkg.sv @@
// Shared types, constants and arithmetic helpers for the biquad IIR unit.
`default_nettype none

package biq_pkg;

  // Sizes
  localparam int CHANNELS  = 4;
  localparam int FRAC_BITS = 30;
  localparam int NUM_REGS  = 6;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W     = 3;
  localparam int SMP_W     = 32;
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + 2;

  // Cycles from an accepted input word to its result word, output free
  localparam int ITEM_CYCLES = 11;

  // Coefficient register indexes
  localparam logic [IDX_W-1:0] REG_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_FB1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_FB2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FF0  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FF1  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FF2  = 3'd5;

  // Product term codes within one three-term sum
  localparam logic [1:0] TERM_NEW   = 2'd0;
  localparam logic [1:0] TERM_NEWER = 2'd1;
  localparam logic [1:0] TERM_OLDER = 2'd2;

  typedef struct packed {
    logic [1:0]              channel;
    logic signed [SMP_W-1:0] sample_in;
  } biq_in_t;

  typedef struct packed {
    logic [1:0]              channel_out;
    logic signed [SMP_W-1:0] sample_out;
  } biq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       acc_load;
    logic       acc_add;
    logic [1:0] term;
    logic       phase_y;
    logic       sat_w;
    logic       finish;
  } biq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } biq_sts_t;

  // Fold the raw channel field onto the implemented channels
  function automatic logic [CH_W-1:0] chan_idx(input logic [1:0] ch);
    logic [2:0] v;
    v = {1'b0, ch};
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= CHANNELS) begin
        v = v - 3'(CHANNELS);
      end
    end
    return CH_W'(v);
  endfunction

  // Arithmetic shift down by the fraction width, then clamp to 32 bits
  function automatic logic signed [SMP_W-1:0] sat_shift(
    input logic signed [ACC_W-1:0] a
  );
    localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SMP_W){1'b0}}, 1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-SMP_W){1'b1}}, 1'b1, {(SMP_W-1){1'b0}}};
    logic signed [ACC_W-1:0] s;
    s = a >>> FRAC_BITS;
    if (s > SAT_HI) begin
      return SAT_HI[SMP_W-1:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[SMP_W-1:0];
    end
    return s[SMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/multichannel_biquad_iir_unit.sv @@
// Top level of the four-channel direct form II biquad IIR unit.
// Each input word names a channel and a signed 32-bit sample; the unit forms
// w = g*x + f1*w1 + f2*w2 and y = b0*w + b1*w1 + b2*w2 on that channel's delay
// pair, each sum exact, shifted down by FRAC_BITS toward minus infinity and
// clamped to 32 bits, and returns one result word per input word. One 32x32
// multiplier is shared by all six products, so an item passes in turn through
// a capture step, the multiply/accumulate steps of the w sum, a clamp step,
// the multiply/accumulate steps of the y sum and a write-back step into the
// output register, and one item is in work at a time; the next word is taken
// the cycle after write-back. A result waiting in the output register only
// holds up the write-back step. Coefficient writes (index 0..5, others
// ignored) are always ready and belong to idle periods.
`default_nettype none

module multichannel_biquad_iir_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire biq_pkg::biq_in_t                 in_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output biq_pkg::biq_out_t                     out_word,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [biq_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic signed [biq_pkg::SMP_W-1:0] cfg_data
);
  import biq_pkg::*;

  biq_cmd_t cmd;
  biq_sts_t sts;

  assign cfg_ready = 1'b1;

  biq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  biq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

@@ hw/rtl/biq_ctrl.sv @@
// Sequencing state machine for the biquad IIR unit.
`default_nettype none

module biq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire biq_pkg::biq_sts_t sts,
  output biq_pkg::biq_cmd_t      cmd
);
  import biq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_SAT  = 4'b0100,
    S_DONE = 4'b1000
  } biq_state_t;

  localparam logic [1:0] STEP_FIRST_SUM = 2'd1;
  localparam logic [1:0] STEP_LAST      = 2'd3;

  biq_state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       phase_r, phase_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_nxt    = '0;
          phase_nxt   = 1'b0;
          state_nxt   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.term     = step_r;
        cmd.phase_y  = phase_r;
        cmd.mul_en   = (step_r != STEP_LAST);
        cmd.acc_load = (step_r == STEP_FIRST_SUM);
        cmd.acc_add  = (step_r > STEP_FIRST_SUM);
        step_nxt     = step_r + 2'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = phase_r ? S_DONE : S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat_w = 1'b1;
        phase_nxt = 1'b1;
        step_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/biq_datapath.sv @@
// Coefficients, channel delays, shared multiplier, accumulator and output register.
`default_nettype none

module biq_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire biq_pkg::biq_in_t                      in_word,
  input  wire logic                                  cfg_wr,
  input  wire logic [biq_pkg::IDX_W-1:0]             cfg_index,
  input  wire logic signed [biq_pkg::SMP_W-1:0]      cfg_data,
  input  wire biq_pkg::biq_cmd_t                     cmd,
  output biq_pkg::biq_sts_t                          sts,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output biq_pkg::biq_out_t                          out_word
);
  import biq_pkg::*;

  logic signed [SMP_W-1:0]  coef_r [NUM_REGS];
  logic signed [SMP_W-1:0]  delay_newer_r [CHANNELS];
  logic signed [SMP_W-1:0]  delay_older_r [CHANNELS];
  logic signed [SMP_W-1:0]  x_r;
  logic signed [SMP_W-1:0]  w_r;
  logic [1:0]               ch_raw_r;
  logic [CH_W-1:0]          ch_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r, out_valid_nxt;
  biq_out_t                 out_word_r;

  logic signed [SMP_W-1:0]  opa;
  logic signed [SMP_W-1:0]  opc;
  logic signed [ACC_W-1:0]  prod_ext;

  // Coefficient registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr && (cfg_index < IDX_W'(NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    case (cmd.term)
      TERM_NEW: begin
        opa = cmd.phase_y ? w_r : x_r;
        opc = cmd.phase_y ? coef_r[REG_FF0] : coef_r[REG_GAIN];
      end
      TERM_NEWER: begin
        opa = delay_newer_r[ch_r];
        opc = cmd.phase_y ? coef_r[REG_FF1] : coef_r[REG_FB1];
      end
      TERM_OLDER: begin
        opa = delay_older_r[ch_r];
        opc = cmd.phase_y ? coef_r[REG_FF2] : coef_r[REG_FB2];
      end
      default: begin
        opa = '0;
        opc = '0;
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Capture input, multiply, accumulate, clamp the intermediate value
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r      <= in_word.sample_in;
      ch_raw_r <= in_word.channel;
      ch_r     <= chan_idx(in_word.channel);
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(opa) * PROD_W'(opc);
    end
    if (cmd.acc_load) begin
      acc_r <= prod_ext;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
    if (cmd.sat_w) begin
      w_r <= sat_shift(acc_r);
    end
  end

  // Shift the channel's delay pair when its result is written to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        delay_newer_r[i] <= '0;
        delay_older_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      delay_older_r[ch_r] <= delay_newer_r[ch_r];
      delay_newer_r[ch_r] <= w_r;
    end
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word_r.channel_out <= ch_raw_r;
      out_word_r.sample_out  <= sat_shift(acc_r);
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

endmodule

`default_nettype wire

@@ hw/rtl/biq_checker.sv @@
// Port-level checks for the biquad IIR unit, bound to the top level.
`default_nettype none

module biq_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  input  wire logic                             in_stall,
  input  wire biq_pkg::biq_in_t                 in_word,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire biq_pkg::biq_out_t                out_word,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [biq_pkg::IDX_W-1:0]        cfg_index
);
  import biq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // No second word while one is in work
  a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken on the cycle after an accept");

  a_busy_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(ITEM_CYCLES-1) in_stall)
    else $error("input taken before the previous word finished");

  // A fresh result word comes from the word accepted a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, ITEM_CYCLES) &&
      (out_word.channel_out == $past(in_word.channel, ITEM_CYCLES)))
    else $error("result word does not match the accepted word");

  // Configuration is only written while the unit is idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_REGS)) |-> !in_stall)
    else $error("coefficient written while a word is in work");

endmodule

bind multichannel_biquad_iir_unit biq_checker u_biq_checker (.*);

`default_nettype wire
